// File: rtl/segment_obstacle_intersection_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the obstacle segment intersection block
// Shared clocked assertion forms with reset disable.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_OBSTACLE_INTERSECTION_MACROS_SVH
`define SEGMENT_OBSTACLE_INTERSECTION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SOI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SOI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/soi_pkg.sv
// ----------------------------------------------------------------------------
// soi_pkg
// Shared types and request codes for the obstacle segment intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package soi_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Status of the edge test pipeline as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic hit;
  } unit_stat_t;

endpackage

// File: rtl/soi_edge_mem.sv
// ----------------------------------------------------------------------------
// soi_edge_mem
// Obstacle edge storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module soi_edge_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/soi_edge_unit.sv
// ----------------------------------------------------------------------------
// soi_edge_unit
// Pipelined edge test shared by all stored edges: differences, cross
// products, numerators and denominator, sign fold, then range compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module soi_edge_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           iss_vld,
  input  logic [4*COORD_BITS-1:0]        edge_data,
  input  logic signed [COORD_BITS-1:0]   q_ax,
  input  logic signed [COORD_BITS-1:0]   q_ay,
  input  logic signed [COORD_BITS-1:0]   q_bx,
  input  logic signed [COORD_BITS-1:0]   q_by,
  output soi_pkg::unit_stat_t            stat
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic signed [CB-1:0] cx, cy, dx, dy;

  logic signed [DW-1:0] abx_r, aby_r, cdx_r, cdy_r, acx_r, acy_r;
  logic signed [PW-1:0] p_den1_r, p_den2_r, p_r1_r, p_r2_r, p_s1_r, p_s2_r;
  logic signed [NW-1:0] den_r, rnum_r, snum_r;
  logic signed [NW-1:0] den_a_r, rnum_a_r, snum_a_r;
  logic                 nz_r;
  logic                 hit;

  assign cx = edge_data[4*CB-1:3*CB];
  assign cy = edge_data[3*CB-1:2*CB];
  assign dx = edge_data[2*CB-1:CB];
  assign dy = edge_data[CB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= iss_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Payload stages carry no reset; the valid chain above qualifies them.
  always_ff @(posedge clk) begin
    abx_r <= $signed({q_bx[CB-1], q_bx}) - $signed({q_ax[CB-1], q_ax});
    aby_r <= $signed({q_by[CB-1], q_by}) - $signed({q_ay[CB-1], q_ay});
    cdx_r <= $signed({dx[CB-1], dx}) - $signed({cx[CB-1], cx});
    cdy_r <= $signed({dy[CB-1], dy}) - $signed({cy[CB-1], cy});
    acx_r <= $signed({q_ax[CB-1], q_ax}) - $signed({cx[CB-1], cx});
    acy_r <= $signed({q_ay[CB-1], q_ay}) - $signed({cy[CB-1], cy});

    p_den1_r <= abx_r * cdy_r;
    p_den2_r <= aby_r * cdx_r;
    p_r1_r   <= acy_r * cdx_r;
    p_r2_r   <= acx_r * cdy_r;
    p_s1_r   <= acy_r * abx_r;
    p_s2_r   <= acx_r * aby_r;

    den_r  <= $signed({p_den1_r[PW-1], p_den1_r}) - $signed({p_den2_r[PW-1], p_den2_r});
    rnum_r <= $signed({p_r1_r[PW-1], p_r1_r}) - $signed({p_r2_r[PW-1], p_r2_r});
    snum_r <= $signed({p_s1_r[PW-1], p_s1_r}) - $signed({p_s2_r[PW-1], p_s2_r});

    // Fold the sign of the denominator into both numerators.
    nz_r     <= (den_r != '0);
    den_a_r  <= den_r[NW-1] ? -den_r  : den_r;
    rnum_a_r <= den_r[NW-1] ? -rnum_r : rnum_r;
    snum_a_r <= den_r[NW-1] ? -snum_r : snum_r;
  end

  // Strictly inside along the query segment, closed range along the edge.
  assign hit = v5_r && nz_r
               && !rnum_a_r[NW-1] && (rnum_a_r != '0) && (rnum_a_r < den_a_r)
               && !snum_a_r[NW-1] && (snum_a_r <= den_a_r);

  assign stat.busy = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign stat.hit  = hit;

endmodule

// File: rtl/segment_obstacle_intersection.sv
// ----------------------------------------------------------------------------
// segment_obstacle_intersection
// Obstacle edge table with a segment crossing test.
//
//   Channel | Ports                                    | Direction
//   --------+------------------------------------------+-----------
//   in      | in_valid, in_stall, in_opcode, in_ax,    | request in
//           | in_ay, in_bx, in_by_coord                |
//   out     | out_valid, out_stall, out_blocked,       | result out
//           | out_status                               |
//
// Clear, append and unused opcodes give their result on the next cycle.
// A query streams the stored edges through the test pipeline, one edge per
// cycle, and answers once the last edge has left the pipeline; an empty table
// answers without reading any edge. One request is in work at a time.
// Reset empties the table at once; entries beyond the count are never read.
// A held result stalls new requests only until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_obstacle_intersection_macros.svh"

module segment_obstacle_intersection #(
  parameter int MAX_EDGES  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic signed [COORD_BITS-1:0]  in_ax,
  input  logic signed [COORD_BITS-1:0]  in_ay,
  input  logic signed [COORD_BITS-1:0]  in_bx,
  input  logic signed [COORD_BITS-1:0]  in_by_coord,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_blocked,
  output logic                          out_status
);

  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = 4 * COORD_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          blocked_r, blocked_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_blocked_r, out_blocked_nxt;
  logic          out_status_r, out_status_nxt;

  logic signed [COORD_BITS-1:0] q_ax_r, q_ay_r, q_bx_r, q_by_r;

  logic                in_acc;
  logic                out_free;
  logic                app_ok;
  logic                app_refused;
  logic                st_idle;
  logic                wr_en;
  logic                iss_vld;
  logic                scan_done;
  logic [EW-1:0]       edge_data;
  soi_pkg::unit_stat_t ustat;

  assign st_idle     = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = !(st_idle && out_free);
  assign in_acc      = in_valid && !in_stall;
  assign app_ok      = (count_r < CW'(MAX_EDGES));
  assign wr_en       = in_acc && (in_opcode == soi_pkg::OP_APPEND) && app_ok;
  assign app_refused = in_acc && (in_opcode == soi_pkg::OP_APPEND) && !app_ok;
  assign iss_vld     = (state_r == ST_SCAN) && (idx_r != count_r);
  assign scan_done   = (state_r == ST_SCAN) && (idx_r == count_r) && !ustat.busy;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    blocked_nxt     = blocked_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_blocked_nxt = out_blocked_r;
    out_status_nxt  = out_status_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_opcode)
            soi_pkg::OP_QUERY: begin
              state_nxt   = ST_SCAN;
              idx_nxt     = '0;
              blocked_nxt = 1'b0;
            end
            soi_pkg::OP_CLEAR: begin
              count_nxt       = '0;
              out_valid_nxt   = 1'b1;
              out_blocked_nxt = 1'b0;
              out_status_nxt  = 1'b0;
            end
            soi_pkg::OP_APPEND: begin
              if (app_ok) begin
                count_nxt = count_r + CW'(1);
              end
              out_valid_nxt   = 1'b1;
              out_blocked_nxt = 1'b0;
              out_status_nxt  = !app_ok;
            end
            default: begin
              out_valid_nxt   = 1'b1;
              out_blocked_nxt = 1'b0;
              out_status_nxt  = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (iss_vld) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (ustat.hit) begin
          blocked_nxt = 1'b1;
        end
        // The output register is empty here: a query is taken only when it is.
        if (scan_done) begin
          state_nxt       = ST_IDLE;
          out_valid_nxt   = 1'b1;
          out_blocked_nxt = blocked_r;
          out_status_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      blocked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      blocked_r   <= blocked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_blocked_r <= out_blocked_nxt;
    out_status_r  <= out_status_nxt;
    if (in_acc && (in_opcode == soi_pkg::OP_QUERY)) begin
      q_ax_r <= in_ax;
      q_ay_r <= in_ay;
      q_bx_r <= in_bx;
      q_by_r <= in_by_coord;
    end
  end

  soi_edge_mem #(
    .DEPTH (MAX_EDGES),
    .AW    (AW),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({in_ax, in_ay, in_bx, in_by_coord}),
    .rd_en   (iss_vld),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (edge_data)
  );

  soi_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_vld   (iss_vld),
    .edge_data (edge_data),
    .q_ax      (q_ax_r),
    .q_ay      (q_ay_r),
    .q_bx      (q_bx_r),
    .q_by      (q_by_r),
    .stat      (ustat)
  );

  assign out_valid   = out_valid_r;
  assign out_blocked = out_blocked_r;
  assign out_status  = out_status_r;

  `SOI_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_EDGES), "edge count above table size")
  `SOI_ASSERT_NOW(a_issue_in_range, iss_vld, idx_r < count_r, "edge read beyond stored edges")
  `SOI_ASSERT_NEXT(a_scan_result, scan_done, out_valid_r && st_idle, "query gave no result")
  `SOI_ASSERT_NEXT(a_full_refused, app_refused, out_status_r, "full append not refused")
  `SOI_ASSERT_NEXT(a_full_keep, app_refused, $stable(count_r), "table grew on full append")
  `SOI_ASSERT_NOW(a_idle_quiet, st_idle, !ustat.busy, "edge test active while idle")

endmodule

// File: dv/tb_segment_obstacle_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_obstacle_intersection
// Self-checking bench for the obstacle edge table and its segment crossing
// test. A scoreboard keeps its own copy of the edge table and works out the
// answer to each accepted request with exact integer cross products. Directed
// requests cover the corner cases. Random scenes follow, most with a clear,
// a batch of edges and a batch of queries, many aimed through or at stored
// edges. Both channels idle at random in the first two of three phases.
// ----------------------------------------------------------------------------

module tb_segment_obstacle_intersection;

  localparam int MAX_EDGES       = 64;
  localparam int COORD_BITS      = 16;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = MAX_EDGES + 16;

  localparam logic [1:0] OP_CLEAR  = soi_pkg::OP_CLEAR;
  localparam logic [1:0] OP_APPEND = soi_pkg::OP_APPEND;
  localparam logic [1:0] OP_QUERY  = soi_pkg::OP_QUERY;
  localparam logic [1:0] OP_UNUSED = soi_pkg::OP_UNUSED;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t cx, cy, dx, dy;
  } obstacle_edge_t;

  typedef struct {
    logic blocked;
    logic status;
  } answer_t;

  // Mirrors the edge table and holds the answers still owed by the block.
  class crossing_tracker;
    obstacle_edge_t edge_tab[MAX_EDGES];
    int unsigned    edge_cnt;
    answer_t        answers_due[$];
    int             failures;

    function new();
      edge_cnt = 0;
      failures = 0;
    endfunction

    function bit segment_crosses(obstacle_edge_t e, coord_t ax, coord_t ay,
                                 coord_t bx, coord_t byc);
      longint abx, aby, cdx, cdy, acx, acy, den, rnum, snum;
      abx  = longint'(bx) - longint'(ax);
      aby  = longint'(byc) - longint'(ay);
      cdx  = longint'(e.dx) - longint'(e.cx);
      cdy  = longint'(e.dy) - longint'(e.cy);
      acx  = longint'(ax) - longint'(e.cx);
      acy  = longint'(ay) - longint'(e.cy);
      den  = abx * cdy - aby * cdx;
      rnum = acy * cdx - acx * cdy;
      snum = acy * abx - acx * aby;
      if (den == 0) return 1'b0;
      if (den < 0) begin
        den  = -den;
        rnum = -rnum;
        snum = -snum;
      end
      // The crossing must lie strictly between A and B, but may sit on C or D.
      return (rnum > 0) && (rnum < den) && (snum >= 0) && (snum <= den);
    endfunction

    function void note_request(logic [1:0] op, coord_t ax, coord_t ay,
                               coord_t bx, coord_t byc);
      answer_t ans;
      ans.blocked = 1'b0;
      ans.status  = 1'b0;
      case (op)
        OP_CLEAR: begin
          edge_cnt = 0;
        end
        OP_APPEND: begin
          if (edge_cnt < MAX_EDGES) begin
            edge_tab[edge_cnt] = '{cx: ax, cy: ay, dx: bx, dy: byc};
            edge_cnt++;
          end else begin
            ans.status = 1'b1;
          end
        end
        OP_QUERY: begin
          for (int i = 0; i < edge_cnt; i++) begin
            if (segment_crosses(edge_tab[i], ax, ay, bx, byc)) ans.blocked = 1'b1;
          end
        end
        default: ;
      endcase
      answers_due.insert(answers_due.size(), ans);
    endfunction

    function void check_answer(logic blocked, logic status);
      answer_t want;
      if (answers_due.size() == 0) begin
        $error("result with no request pending: blocked=%b status=%b", blocked, status);
        failures++;
        return;
      end
      want = answers_due.pop_front();
      if (blocked !== want.blocked) begin
        $error("blocked: expected %b, got %b", want.blocked, blocked);
        failures++;
      end
      if (status !== want.status) begin
        $error("status: expected %b, got %b", want.status, status);
        failures++;
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [1:0] in_opcode   = OP_CLEAR;
  coord_t     in_ax       = '0;
  coord_t     in_ay       = '0;
  coord_t     in_bx       = '0;
  coord_t     in_by_coord = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic       out_blocked;
  logic       out_status;

  crossing_tracker tracker;
  obstacle_edge_t  stim_edges[$];
  int              requests_sent = 0;
  int              snd_idle_pct  = 20;
  int              rcv_idle_pct  = 73;
  int              cycle_count   = 0;

  segment_obstacle_intersection DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_ax       (in_ax),
    .in_ay       (in_ay),
    .in_bx       (in_bx),
    .in_by_coord (in_by_coord),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_blocked (out_blocked),
    .out_status  (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: take what is offered, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_answer(out_blocked, out_status);
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // Valid stays high from one request to the next when no gap is drawn.
  task automatic send_request(logic [1:0] op, coord_t ax, coord_t ay,
                              coord_t bx, coord_t byc);
    obstacle_edge_t ne;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_ax       <= ax;
    in_ay       <= ay;
    in_bx       <= bx;
    in_by_coord <= byc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(op, ax, ay, bx, byc);
    if (op == OP_CLEAR) stim_edges.delete();
    if (op == OP_APPEND && stim_edges.size() < MAX_EDGES) begin
      ne = '{cx: ax, cy: ay, dx: bx, dy: byc};
      stim_edges.insert(stim_edges.size(), ne);
    end
    if (op != OP_UNUSED) requests_sent++;
  endtask

  function automatic coord_t rand_coord(bit narrow);
    if (narrow) return coord_t'(int'($urandom_range(128)) - 64);
    return coord_t'($urandom());
  endfunction

  // Queries either pass through the middle of a stored edge, start or end on
  // one of its endpoints, or go anywhere.
  task automatic issue_query(bit narrow);
    int             pick;
    obstacle_edge_t e;
    coord_t         mx, my, vx, vy;
    pick = $urandom_range(99);
    if (stim_edges.size() != 0 && pick < 55) begin
      e = stim_edges[$urandom_range(stim_edges.size() - 1)];
      if (pick < 40) begin
        mx = coord_t'((int'(e.cx) + int'(e.dx)) >>> 1);
        my = coord_t'((int'(e.cy) + int'(e.dy)) >>> 1);
        vx = narrow ? coord_t'(int'($urandom_range(80)) - 40) : rand_coord(1'b0);
        vy = narrow ? coord_t'(int'($urandom_range(80)) - 40) : rand_coord(1'b0);
        send_request(OP_QUERY, mx - vx, my - vy, mx + vx, my + vy);
      end else if (pick < 48) begin
        send_request(OP_QUERY, e.cx, e.cy, rand_coord(narrow), rand_coord(narrow));
      end else begin
        send_request(OP_QUERY, rand_coord(narrow), rand_coord(narrow), e.dx, e.dy);
      end
    end else begin
      send_request(OP_QUERY, rand_coord(narrow), rand_coord(narrow),
                   rand_coord(narrow), rand_coord(narrow));
    end
  endtask

  task automatic run_scene(bit fill);
    int n_edges, n_queries;
    bit narrow;
    narrow = ($urandom_range(3) != 0);
    if ($urandom_range(9) != 0)
      send_request(OP_CLEAR, rand_coord(1'b0), rand_coord(1'b0),
                   rand_coord(1'b0), rand_coord(1'b0));
    n_edges = fill ? $urandom_range(70, 64) : $urandom_range(12);
    for (int k = 0; k < n_edges; k++)
      send_request(OP_APPEND, rand_coord(narrow), rand_coord(narrow),
                   rand_coord(narrow), rand_coord(narrow));
    n_queries = $urandom_range(10, 3);
    for (int k = 0; k < n_queries; k++) begin
      if ($urandom_range(29) == 0)
        send_request(OP_UNUSED, rand_coord(1'b0), rand_coord(1'b0),
                     rand_coord(1'b0), rand_coord(1'b0));
      else if ($urandom_range(14) == 0)
        send_request(OP_APPEND, rand_coord(narrow), rand_coord(narrow),
                     rand_coord(narrow), rand_coord(narrow));
      else
        issue_query(narrow);
    end
  endtask

  initial begin
    bit first_scene;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part around one horizontal edge from (-10,0) to (10,0).
    send_request(OP_QUERY, 0, -10, 0, 10);            // empty table
    send_request(OP_APPEND, -10, 0, 10, 0);
    send_request(OP_QUERY, 0, -10, 0, 10);            // clean crossing
    send_request(OP_QUERY, 0, 0, 0, 10);              // touches at A only
    send_request(OP_QUERY, 0, -10, 0, 0);             // touches at B only
    send_request(OP_QUERY, -10, -5, -10, 5);          // through endpoint C
    send_request(OP_QUERY, 10, -5, 10, 5);            // through endpoint D
    send_request(OP_QUERY, -10, 5, 10, 5);            // parallel
    send_request(OP_QUERY, -20, 0, 20, 0);            // collinear overlap
    send_request(OP_APPEND, 3, 3, 3, 3);              // degenerate edge
    send_request(OP_QUERY, 0, 3, 6, 3);
    send_request(OP_QUERY, -32768, -32768, 32767, 32767);
    send_request(OP_APPEND, -32768, 32767, 32767, -32768);
    send_request(OP_QUERY, -32768, -32768, -32768, 32767);
    send_request(OP_QUERY, 32767, 32767, -32768, -32768);
    send_request(OP_QUERY, -32768, 0, 32767, 0);
    send_request(OP_UNUSED, -32768, 32767, -32768, 32767);
    send_request(OP_QUERY, 0, -10, 0, 10);
    send_request(OP_CLEAR, 32767, -32768, 32767, -32768);
    send_request(OP_QUERY, 0, -10, 0, 10);            // nothing left to hit
    send_request(OP_APPEND, -1, -1, 1, 1);
    send_request(OP_QUERY, -1, 1, 1, -1);

    // Random scenes; the first one fills the table and may overfill it.
    requests_sent = 0;
    first_scene   = 1'b1;
    while (requests_sent < RANDOM_REQUESTS) begin
      if (requests_sent < RANDOM_REQUESTS / 3) begin
        snd_idle_pct = 20;
        rcv_idle_pct = 73;
      end else if (requests_sent < 2 * RANDOM_REQUESTS / 3) begin
        snd_idle_pct = 73;
        rcv_idle_pct = 20;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      run_scene(first_scene || $urandom_range(7) == 0);
      first_scene = 1'b0;
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: segment_obstacle_intersection.f
+incdir+rtl
rtl/soi_pkg.sv
rtl/soi_edge_mem.sv
rtl/soi_edge_unit.sv
rtl/segment_obstacle_intersection.sv
dv/tb_segment_obstacle_intersection.sv
